// ===== sv/cscd_pkg.sv =====
// ----------------------------------------------------------------------------
// cscd_pkg
// Shared types, constants and small helpers for the clock set and display
// controller.
// ----------------------------------------------------------------------------
package cscd_pkg;

  // Operating mode, one-hot
  typedef enum logic [3:0] {
    MODE_RUN  = 4'b0001,
    MODE_HOUR = 4'b0010,
    MODE_MIN  = 4'b0100,
    MODE_SEC  = 4'b1000
  } mode_t;

  // Mode codes as seen on the set_mode port
  localparam logic [1:0] SET_MODE_RUN  = 2'd0;
  localparam logic [1:0] SET_MODE_HOUR = 2'd1;
  localparam logic [1:0] SET_MODE_MIN  = 2'd2;
  localparam logic [1:0] SET_MODE_SEC  = 2'd3;

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  localparam logic [7:0] SEG_BLANK = 8'hff;

  // One poll's result: held time, write request, mode code and show flags, passed from control to display
  typedef struct packed {
    logic       write_req;
    logic [1:0] mode_code;
    logic       show_hour;
    logic       show_min;
    logic       show_sec;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
  } poll_result_t;

  // Common-anode seven-segment patterns
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'hc0;
      4'd1:    pat = 8'hf9;
      4'd2:    pat = 8'ha4;
      4'd3:    pat = 8'hb0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hf8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

  // Tens digit of a value below 64
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Ones digit of a value below 64, given its tens digit
  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] tens10;
    logic [5:0] diff;
    tens10 = {t, 3'b000} - {2'b00, t, 1'b0} + {1'b0, t, 2'b00};
    diff   = v - tens10;
    return diff[3:0];
  endfunction

  // Decode a raw BCD byte as low + 10 * high, saturated to limit
  function automatic logic [5:0] bcd_sat(input logic [7:0] raw, input logic [5:0] limit);
    logic [7:0] hi8;
    logic [7:0] val;
    hi8 = {4'b0000, raw[7:4]};
    val = {hi8[4:0], 3'b000} + {hi8[6:0], 1'b0} + {4'b0000, raw[3:0]};
    return (val > {2'b00, limit}) ? limit : val[5:0];
  endfunction

endpackage

// ===== sv/cscd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cscd_ctrl
// Key edge detection, mode sequencing, time adjust and RTC write/load
// decision. Holds the controller state and advances it once per transaction.
// ----------------------------------------------------------------------------
module cscd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  set_key,
  input  logic                  up_key,
  input  logic                  down_key,
  input  logic [7:0]            rtc_seconds_bcd,
  input  logic [7:0]            rtc_minutes_bcd,
  input  logic [7:0]            rtc_hours_bcd,
  output cscd_pkg::poll_result_t result
);
  import cscd_pkg::*;

  mode_t      mode, mode_next;
  logic [4:0] hours_count, hours_count_next;
  logic [5:0] minutes_count, minutes_count_next;
  logic [5:0] seconds_count, seconds_count_next;
  logic       rtc_dirty, rtc_dirty_next;
  logic       set_key_prev;
  logic       up_key_prev, up_key_prev_next;
  logic       down_key_prev, down_key_prev_next;

  logic       up_press, down_press, write_req;
  logic [4:0] hours_up;
  logic [5:0] minutes_up;
  logic [5:0] hours_load;

  always_comb begin
    // Set key falling edge steps the mode
    mode_next = mode;
    if (set_key_prev && !set_key) begin
      case (mode)
        MODE_RUN:  mode_next = MODE_HOUR;
        MODE_HOUR: mode_next = MODE_MIN;
        MODE_MIN:  mode_next = MODE_SEC;
        MODE_SEC:  mode_next = MODE_RUN;
        default:   mode_next = MODE_RUN;
      endcase
    end

    up_press           = 1'b0;
    down_press         = 1'b0;
    up_key_prev_next   = up_key_prev;
    down_key_prev_next = down_key_prev;
    rtc_dirty_next     = rtc_dirty;
    write_req          = 1'b0;
    hours_count_next   = hours_count;
    minutes_count_next = minutes_count;
    seconds_count_next = seconds_count;

    // Up and down are sampled only while setting
    if (mode_next != MODE_RUN) begin
      up_press           = up_key_prev && !up_key;
      down_press         = down_key_prev && !down_key;
      up_key_prev_next   = up_key;
      down_key_prev_next = down_key;
      rtc_dirty_next     = 1'b1;
    end

    hours_up   = (hours_count >= HOUR_MAX) ? 5'd0 : hours_count + 5'd1;
    minutes_up = (minutes_count >= MIN_MAX) ? 6'd0 : minutes_count + 6'd1;
    hours_load = bcd_sat(rtc_hours_bcd, {1'b0, HOUR_MAX});

    case (mode_next)
      MODE_HOUR: begin
        if (up_press) hours_count_next = hours_up;
        if (down_press)
          hours_count_next = (hours_count_next == 5'd0) ? HOUR_MAX
                                                         : hours_count_next - 5'd1;
      end
      MODE_MIN: begin
        if (up_press) minutes_count_next = minutes_up;
        if (down_press)
          minutes_count_next = (minutes_count_next == 6'd0) ? MIN_MAX
                                                             : minutes_count_next - 6'd1;
      end
      MODE_SEC: begin
        if (up_press)
          seconds_count_next = (seconds_count >= SEC_MAX) ? 6'd0 : seconds_count + 6'd1;
        if (down_press) seconds_count_next = 6'd0;
      end
      default: begin
        // Run: flush a dirty time once, otherwise track the RTC
        if (rtc_dirty) begin
          write_req      = 1'b1;
          rtc_dirty_next = 1'b0;
        end else begin
          seconds_count_next = bcd_sat(rtc_seconds_bcd, SEC_MAX);
          minutes_count_next = bcd_sat(rtc_minutes_bcd, MIN_MAX);
          hours_count_next   = hours_load[4:0];
        end
      end
    endcase

    result.write_req = write_req;
    case (mode_next)
      MODE_HOUR: result.mode_code = SET_MODE_HOUR;
      MODE_MIN:  result.mode_code = SET_MODE_MIN;
      MODE_SEC:  result.mode_code = SET_MODE_SEC;
      default:   result.mode_code = SET_MODE_RUN;
    endcase
    result.show_hour = (mode_next == MODE_RUN) || (mode_next == MODE_HOUR);
    result.show_min  = (mode_next == MODE_RUN) || (mode_next == MODE_MIN);
    result.show_sec  = (mode_next == MODE_RUN) || (mode_next == MODE_SEC);
    result.seconds   = seconds_count_next;
    result.minutes   = minutes_count_next;
    result.hours     = hours_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_RUN;
      hours_count   <= 5'd0;
      minutes_count <= 6'd0;
      seconds_count <= 6'd0;
      rtc_dirty     <= 1'b0;
      set_key_prev  <= 1'b1;
      up_key_prev   <= 1'b1;
      down_key_prev <= 1'b1;
    end else if (advance) begin
      mode          <= mode_next;
      hours_count   <= hours_count_next;
      minutes_count <= minutes_count_next;
      seconds_count <= seconds_count_next;
      rtc_dirty     <= rtc_dirty_next;
      set_key_prev  <= set_key;
      up_key_prev   <= up_key_prev_next;
      down_key_prev <= down_key_prev_next;
    end
  end

endmodule

// ===== sv/cscd_disp.sv =====
// ----------------------------------------------------------------------------
// cscd_disp
// Forms the segment bytes, the second bar and the BCD write bytes from the
// held time of one poll.
// ----------------------------------------------------------------------------
module cscd_disp (
  input  cscd_pkg::poll_result_t result,
  output logic [47:0]            digit_segments,
  output logic [63:0]            led_bar,
  output logic [6:0]             write_seconds_bcd,
  output logic [6:0]             write_minutes_bcd,
  output logic [5:0]             write_hours_bcd
);
  import cscd_pkg::*;

  logic [2:0] sec_tens, min_tens, hour_tens;
  logic [3:0] sec_ones, min_ones, hour_ones;

  always_comb begin
    sec_tens  = tens_of(result.seconds);
    min_tens  = tens_of(result.minutes);
    hour_tens = tens_of({1'b0, result.hours});
    sec_ones  = ones_of(result.seconds, sec_tens);
    min_ones  = ones_of(result.minutes, min_tens);
    hour_ones = ones_of({1'b0, result.hours}, hour_tens);

    // In a set mode, blank the fields that are not being set
    digit_segments[7:0]   = result.show_sec  ? seg_of(sec_ones)           : SEG_BLANK;
    digit_segments[15:8]  = result.show_sec  ? seg_of({1'b0, sec_tens})   : SEG_BLANK;
    digit_segments[23:16] = result.show_min  ? seg_of(min_ones)           : SEG_BLANK;
    digit_segments[31:24] = result.show_min  ? seg_of({1'b0, min_tens})   : SEG_BLANK;
    digit_segments[39:32] = result.show_hour ? seg_of(hour_ones)          : SEG_BLANK;
    digit_segments[47:40] = result.show_hour ? seg_of({1'b0, hour_tens})  : SEG_BLANK;

    // Active-low bar: lit up to and including the current second
    for (int i = 0; i < 64; i++) begin
      led_bar[i] = !(i[5:0] <= result.seconds);
    end

    if (result.write_req) begin
      write_seconds_bcd = {sec_tens, sec_ones};
      write_minutes_bcd = {min_tens, min_ones};
      write_hours_bcd   = {hour_tens[1:0], hour_ones};
    end else begin
      write_seconds_bcd = 7'd0;
      write_minutes_bcd = 7'd0;
      write_hours_bcd   = 6'd0;
    end
  end

endmodule

// ===== sv/clock_set_and_display_controller.sv =====
// ----------------------------------------------------------------------------
// clock_set_and_display_controller
// Poll-driven set-mode controller and display encoder for an RTC clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction is one poll of the
//   set, up and down key levels (0 = pressed) together with the raw BCD
//   seconds, minutes and hours bytes read from the RTC.
//   Output channel (out_valid / out_stall): exactly one result per poll,
//   carrying the RTC write request and BCD bytes, the mode code, six
//   segment bytes with unselected fields blanked, and the 64-bit LED bar.
//   Path: a taken poll is held in the input register, then loaded into the
//   output register once that is free, where the receiver can take it.
//   Throughput: one poll per cycle while out_stall is low; all decision
//   logic is combinational between the input and output registers.
//   Stall: while out_stall holds a waiting result, the input register keeps
//   its poll and in_stall rises once that register is also full; nothing is
//   dropped and the controller state advances only when a poll moves on.
//   Reset: run mode, held time 00:00:00, not dirty, key levels taken as
//   released, both pipeline registers empty.
// ----------------------------------------------------------------------------
module clock_set_and_display_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        set_key,
  input  logic        up_key,
  input  logic        down_key,
  input  logic [7:0]  rtc_seconds_bcd,
  input  logic [7:0]  rtc_minutes_bcd,
  input  logic [7:0]  rtc_hours_bcd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        time_write,
  output logic [6:0]  write_seconds_bcd,
  output logic [6:0]  write_minutes_bcd,
  output logic [5:0]  write_hours_bcd,
  output logic [1:0]  set_mode,
  output logic [47:0] digit_segments,
  output logic [63:0] led_bar
);
  import cscd_pkg::*;

  // Input register
  logic       poll_valid;
  logic       poll_set, poll_up, poll_down;
  logic [7:0] poll_sec, poll_min, poll_hour;

  // Pipeline moves when the output register is free or being drained
  logic out_free, poll_advance, in_take;

  poll_result_t result;
  logic [47:0]  segs_d;
  logic [63:0]  bar_d;
  logic [6:0]   wsec_d, wmin_d;
  logic [5:0]   whour_d;

  assign out_free     = !out_valid || !out_stall;
  assign poll_advance = poll_valid && out_free;
  assign in_stall     = poll_valid && !out_free;
  assign in_take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (!poll_valid || out_free) begin
      poll_valid <= in_valid;
    end
  end

  // Capture payload on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      poll_set  <= set_key;
      poll_up   <= up_key;
      poll_down <= down_key;
      poll_sec  <= rtc_seconds_bcd;
      poll_min  <= rtc_minutes_bcd;
      poll_hour <= rtc_hours_bcd;
    end
  end

  cscd_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .advance         (poll_advance),
    .set_key         (poll_set),
    .up_key          (poll_up),
    .down_key        (poll_down),
    .rtc_seconds_bcd (poll_sec),
    .rtc_minutes_bcd (poll_min),
    .rtc_hours_bcd   (poll_hour),
    .result          (result)
  );

  cscd_disp u_disp (
    .result            (result),
    .digit_segments    (segs_d),
    .led_bar           (bar_d),
    .write_seconds_bcd (wsec_d),
    .write_minutes_bcd (wmin_d),
    .write_hours_bcd   (whour_d)
  );

  // Output register: hold while stalled, load when the poll moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_advance) begin
      time_write        <= result.write_req;
      write_seconds_bcd <= wsec_d;
      write_minutes_bcd <= wmin_d;
      write_hours_bcd   <= whour_d;
      set_mode          <= result.mode_code;
      digit_segments    <= segs_d;
      led_bar           <= bar_d;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock set and display controller: a directed
// walk through key edges, field wraps and RTC decode corners, then random
// polls under three idle/stall profiles, all checked against a local model.
// ----------------------------------------------------------------------------
module tb;
  import cscd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  // One poll as driven on the input channel
  typedef struct {
    logic       set_k;
    logic       up_k;
    logic       down_k;
    logic [7:0] sec_raw;
    logic [7:0] min_raw;
    logic [7:0] hour_raw;
  } poll_t;

  // One display result as seen on the output channel
  typedef struct {
    logic        write;
    logic [6:0]  wr_sec;
    logic [6:0]  wr_min;
    logic [5:0]  wr_hour;
    logic [1:0]  mode;
    logic [47:0] segs;
    logic [63:0] bar;
  } clock_view_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        set_key = 1'b1;
  logic        up_key = 1'b1;
  logic        down_key = 1'b1;
  logic [7:0]  rtc_seconds_bcd = 8'h00;
  logic [7:0]  rtc_minutes_bcd = 8'h00;
  logic [7:0]  rtc_hours_bcd = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        time_write;
  logic [6:0]  write_seconds_bcd;
  logic [6:0]  write_minutes_bcd;
  logic [5:0]  write_hours_bcd;
  logic [1:0]  set_mode;
  logic [47:0] digit_segments;
  logic [63:0] led_bar;

  clock_set_and_display_controller i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .set_key           (set_key),
    .up_key            (up_key),
    .down_key          (down_key),
    .rtc_seconds_bcd   (rtc_seconds_bcd),
    .rtc_minutes_bcd   (rtc_minutes_bcd),
    .rtc_hours_bcd     (rtc_hours_bcd),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .time_write        (time_write),
    .write_seconds_bcd (write_seconds_bcd),
    .write_minutes_bcd (write_minutes_bcd),
    .write_hours_bcd   (write_hours_bcd),
    .set_mode          (set_mode),
    .digit_segments    (digit_segments),
    .led_bar           (led_bar)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle profile, changed by each test
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatches = 0;
  int cycles = 0;
  clock_view_t pending_views[$];

  // --------------------------------------------------------------------------
  // Clock model: held time, mode, dirty flag and last key levels, all at
  // their reset values until the first transaction is taken.
  // --------------------------------------------------------------------------
  logic [1:0] cur_mode = SET_MODE_RUN;
  logic [4:0] hold_hours = '0;
  logic [5:0] hold_minutes = '0;
  logic [5:0] hold_seconds = '0;
  logic       time_dirty = 1'b0;
  logic       set_last = 1'b1;
  logic       up_last = 1'b1;
  logic       down_last = 1'b1;

  function automatic logic [7:0] seg_pattern(input int d);
    logic [7:0] pat;
    case (d)
      0:       pat = 8'hc0;
      1:       pat = 8'hf9;
      2:       pat = 8'ha4;
      3:       pat = 8'hb0;
      4:       pat = 8'h99;
      5:       pat = 8'h92;
      6:       pat = 8'h82;
      7:       pat = 8'hf8;
      8:       pat = 8'h80;
      default: pat = 8'h90;
    endcase
    return pat;
  endfunction

  function automatic logic [15:0] digit_pair(input int v, input bit shown);
    if (!shown) return {SEG_BLANK, SEG_BLANK};
    return {seg_pattern((v / 10) % 10), seg_pattern(v % 10)};
  endfunction

  // Raw RTC byte read as low nibble plus ten times high nibble, clipped
  function automatic int rtc_value(input logic [7:0] raw, input int lim);
    int v;
    v = int'(raw[3:0]) + 10 * int'(raw[7:4]);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [7:0] bcd_of(input int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Advance the clock model by one poll and return the display it yields
  function automatic clock_view_t advance_clock(input poll_t p);
    clock_view_t v;
    logic up_hit;
    logic down_hit;
    up_hit = 1'b0;
    down_hit = 1'b0;
    v.write = 1'b0;

    if (set_last && !p.set_k) cur_mode = cur_mode + 2'd1;
    set_last = p.set_k;

    // Up and down are only watched in a set mode; in run mode hold the
    // last levels so a key held through the mode change still counts.
    if (cur_mode != SET_MODE_RUN) begin
      up_hit = up_last && !p.up_k;
      down_hit = down_last && !p.down_k;
      up_last = p.up_k;
      down_last = p.down_k;
      time_dirty = 1'b1;
    end

    case (cur_mode)
      SET_MODE_HOUR: begin
        if (up_hit) hold_hours = (hold_hours >= HOUR_MAX) ? 5'd0 : hold_hours + 5'd1;
        if (down_hit) hold_hours = (hold_hours == 5'd0) ? HOUR_MAX : hold_hours - 5'd1;
      end
      SET_MODE_MIN: begin
        if (up_hit) hold_minutes = (hold_minutes >= MIN_MAX) ? 6'd0 : hold_minutes + 6'd1;
        if (down_hit) hold_minutes = (hold_minutes == 6'd0) ? MIN_MAX : hold_minutes - 6'd1;
      end
      SET_MODE_SEC: begin
        if (up_hit) hold_seconds = (hold_seconds >= SEC_MAX) ? 6'd0 : hold_seconds + 6'd1;
        if (down_hit) hold_seconds = 6'd0;
      end
      default: begin
        // A dirty time goes out once and the RTC bytes of this poll are dropped
        if (time_dirty) begin
          v.write = 1'b1;
          time_dirty = 1'b0;
        end else begin
          hold_seconds = 6'(rtc_value(p.sec_raw, SEC_MAX));
          hold_minutes = 6'(rtc_value(p.min_raw, MIN_MAX));
          hold_hours = 5'(rtc_value(p.hour_raw, HOUR_MAX));
        end
      end
    endcase

    v.wr_sec = v.write ? 7'(bcd_of(hold_seconds)) : 7'd0;
    v.wr_min = v.write ? 7'(bcd_of(hold_minutes)) : 7'd0;
    v.wr_hour = v.write ? 6'(bcd_of(hold_hours)) : 6'd0;
    v.mode = cur_mode;
    v.segs = {digit_pair(hold_hours, cur_mode inside {SET_MODE_RUN, SET_MODE_HOUR}),
              digit_pair(hold_minutes, cur_mode inside {SET_MODE_RUN, SET_MODE_MIN}),
              digit_pair(hold_seconds, cur_mode inside {SET_MODE_RUN, SET_MODE_SEC})};
    v.bar = ~((64'd1 << (hold_seconds + 1)) - 64'd1);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: take the expected view for every accepted poll, then match
  // every accepted result against the oldest one. Both in one process so
  // the order of the two is fixed.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    poll_t       p;
    clock_view_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        p.set_k = set_key;
        p.up_k = up_key;
        p.down_k = down_key;
        p.sec_raw = rtc_seconds_bcd;
        p.min_raw = rtc_minutes_bcd;
        p.hour_raw = rtc_hours_bcd;
        pending_views.push_back(advance_clock(p));
      end
      if (out_valid && !out_stall) begin
        if (pending_views.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual mode %0d",
                   $time, set_mode);
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          check_field("time_write", want.write, time_write);
          check_field("write_seconds_bcd", want.wr_sec, write_seconds_bcd);
          check_field("write_minutes_bcd", want.wr_min, write_minutes_bcd);
          check_field("write_hours_bcd", want.wr_hour, write_hours_bcd);
          check_field("set_mode", want.mode, set_mode);
          check_field("digit_segments", want.segs, digit_segments);
          check_field("led_bar", want.bar, led_bar);
        end
      end
    end
  end

  // Receiver side: stall at random per the current profile
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge once the
  // transaction has been taken. The payload holds while stalled.
  // --------------------------------------------------------------------------
  task automatic send_poll(input logic s, input logic u, input logic d,
                           input logic [7:0] sec, input logic [7:0] mins,
                           input logic [7:0] hrs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    set_key <= s;
    up_key <= u;
    down_key <= d;
    rtc_seconds_bcd <= sec;
    rtc_minutes_bcd <= mins;
    rtc_hours_bcd <= hrs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // RTC byte: mostly legal BCD, some raw noise, some at the corners
  function automatic logic [7:0] rtc_byte(input int lim);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return bcd_of($urandom_range(0, lim));
    if (pick < 8) return 8'($urandom_range(0, 255));
    if (pick == 8) return bcd_of(lim);
    return 8'h00;
  endfunction

  // Random polls: set presses come every few polls so each set mode sees
  // a burst of up and down edges before the mode moves on.
  task automatic random_polls(input int count);
    logic s;
    logic u;
    logic d;
    for (int n = 0; n < count; n++) begin
      s = ($urandom_range(0, 9) >= 2);
      u = ($urandom_range(0, 9) >= 4);
      d = ($urandom_range(0, 9) >= 3);
      send_poll(s, u, d, rtc_byte(SEC_MAX), rtc_byte(MIN_MAX), rtc_byte(HOUR_MAX));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Decode corners, ignored keys in run mode, every wrap and the write poll
  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_poll(1, 1, 1, 8'h00, 8'h00, 8'h00);
    send_poll(1, 1, 1, 8'h59, 8'h59, 8'h23);
    send_poll(1, 1, 1, 8'hff, 8'hff, 8'hff);   // clip to 59 / 59 / 23
    send_poll(1, 1, 1, 8'h0f, 8'h5a, 8'h24);   // bad nibbles, one over the limit
    // Run mode: up/down low are not seen, last levels stay released
    send_poll(1, 0, 0, 8'h59, 8'h00, 8'h00);
    // Hour mode: down wraps 0 -> 23, up wraps 23 -> 0
    send_poll(0, 1, 0, 8'h11, 8'h11, 8'h11);
    send_poll(0, 0, 1, 8'h11, 8'h11, 8'h11);
    send_poll(0, 1, 1, 8'h11, 8'h11, 8'h11);
    send_poll(0, 1, 0, 8'h11, 8'h11, 8'h11);
    send_poll(1, 1, 1, 8'h11, 8'h11, 8'h11);
    // Minute mode: down wraps 0 -> 59, up wraps 59 -> 0, up once more
    send_poll(0, 1, 0, 8'h22, 8'h22, 8'h22);
    send_poll(0, 0, 1, 8'h22, 8'h22, 8'h22);
    send_poll(0, 1, 1, 8'h22, 8'h22, 8'h22);
    send_poll(1, 0, 1, 8'h22, 8'h22, 8'h22);
    // Second mode: up wraps 59 -> 0, up again, down clears
    send_poll(0, 1, 1, 8'h33, 8'h33, 8'h33);
    send_poll(0, 0, 1, 8'h33, 8'h33, 8'h33);
    send_poll(0, 1, 1, 8'h33, 8'h33, 8'h33);
    send_poll(0, 0, 1, 8'h33, 8'h33, 8'h33);
    send_poll(0, 1, 0, 8'h33, 8'h33, 8'h33);
    send_poll(1, 1, 1, 8'h33, 8'h33, 8'h33);
    // Back to run: write the held time once, RTC bytes dropped, then load
    send_poll(0, 1, 1, 8'h12, 8'h34, 8'h05);
    send_poll(1, 1, 1, 8'h12, 8'h34, 8'h05);
    send_poll(1, 1, 1, 8'ha5, 8'h5a, 8'h3c);
  endtask

  task automatic test_slow_receiver;
    send_idle_pct = 33;
    recv_stall_pct = 78;
    random_polls(310);
  endtask

  task automatic test_slow_sender;
    send_idle_pct = 78;
    recv_stall_pct = 33;
    random_polls(310);
  endtask

  task automatic test_full_rate;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_polls(310);
  endtask

  initial begin
    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed;
    test_slow_receiver;
    test_slow_sender;
    test_full_rate;
    in_valid <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (pending_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
